// ===== hw/rtl/slab_pkg.sv =====
// shared types and constants of the slab object allocator
`default_nettype none

package slab_pkg;

    localparam int ADDR_W     = 48;
    localparam int SIZE_REG_W = 13;
    localparam int LIMIT_W    = 5;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int PAGE_OUT_W = 4;
    localparam int SLOT_OUT_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 4096;
    localparam int SIZE_W     = 14;
    localparam int DIVIDEND_W = 12;

    localparam int DEF_MAX_PAGES         = 16;
    localparam int DEF_PAGE_HEADER_BYTES = 64;
    localparam int DEF_MAX_SLOTS         = 512;

    localparam logic [ADDR_W-1:0]     RST_POOL_BASE   = '0;
    localparam logic [SIZE_REG_W-1:0] RST_OBJECT_SIZE = 13'd256;
    localparam logic [LIMIT_W-1:0]    RST_PAGE_LIMIT  = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_OOM      = 2'd1,
        ST_NO_PAGE  = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_OBJECT_SIZE = 2'd1,
        CFG_PAGE_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [SIZE_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [SIZE_W-1:0]     remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slab_if.sv =====
// channel interfaces: command, result and configuration write
`default_nettype none

interface slab_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [slab_pkg::CMD_W-1:0]    command;
    logic [slab_pkg::ADDR_W-1:0]   address;
    modport source (output valid, command, address, input ready);
    modport sink   (input valid, command, address, output ready);
endinterface

interface slab_res_if;
    logic                            valid;
    logic                            ready;
    logic [slab_pkg::STATUS_W-1:0]   status;
    logic [slab_pkg::ADDR_W-1:0]     object_address;
    logic [slab_pkg::PAGE_OUT_W-1:0] page_index;
    logic [slab_pkg::SLOT_OUT_W-1:0] slot_index;
    logic                            took_new_page;
    modport source (output valid, status, object_address, page_index, slot_index,
                    took_new_page, input ready);
    modport sink   (input valid, status, object_address, page_index, slot_index,
                    took_new_page, output ready);
endinterface

interface slab_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [slab_pkg::CFG_IDX_W-1:0] index;
    logic [slab_pkg::ADDR_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slab_object_allocator_unit.sv =====
// slab object allocator: per-page LIFO free lists held in two synchronous memories
//
// channels: cmd takes a command (allocate, free, release all) and a byte address;
// res returns one transaction per command with status, object address, page and
// slot; cfg writes pool_base, object_size and page_limit and is always ready.
// one command is handled at a time; cmd is ready while the block is idle, even
// when the previous result still waits in the output register.
// steps from the accepting edge to res.valid, using the page memory read and
// the shared divider:
//   allocate from a held page: the pages are scanned newest first, then a pop
//   allocate opening a page: the scan, a division for slots per page, a link
//   sweep (one slot a cycle) and a pop; out of memory: the scan alone
//   free: two 12-step divisions for slot count and slot
//   release or unused command: straight to the result
// reset empties all pages (pages_taken is the fill count of the page memory,
// so no clearing pass) and loads the register reset values.
// a stalled receiver holds the result; the next command may run up to its end
// and then waits for the output register to drain.
`default_nettype none

module slab_object_allocator_unit #(
    parameter int MAX_PAGES         = slab_pkg::DEF_MAX_PAGES,
    parameter int PAGE_HEADER_BYTES = slab_pkg::DEF_PAGE_HEADER_BYTES,
    parameter int MAX_SLOTS         = slab_pkg::DEF_MAX_SLOTS
) (
    input wire logic  clk,
    input wire logic  rst_n,
    slab_cmd_if.sink  cmd,
    slab_res_if.source res,
    slab_cfg_if.sink  cfg
);

    localparam int ADDR_W  = slab_pkg::ADDR_W;
    localparam int DW      = slab_pkg::DIVIDEND_W;
    localparam int SZW     = slab_pkg::SIZE_W;
    localparam int PSH     = slab_pkg::PAGE_SHIFT;
    localparam int PGN_W   = ADDR_W - PSH;
    localparam int PW      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PTW     = $clog2(MAX_PAGES + 1);
    localparam int SW      = $clog2(MAX_SLOTS);
    localparam int HW      = SW + 1;
    localparam int FW      = $clog2(MAX_SLOTS + 1);
    localparam int PEW     = FW + HW;
    localparam int LDEPTH  = MAX_PAGES * MAX_SLOTS;
    localparam int LAW     = $clog2(LDEPTH);
    localparam int AVAIL   = slab_pkg::PAGE_BYTES - PAGE_HEADER_BYTES;
    localparam int CW      = (PTW > slab_pkg::LIMIT_W) ? PTW : slab_pkg::LIMIT_W;
    localparam int PRW     = SW + SZW;
    localparam logic [HW-1:0] LIST_EMPTY = {HW{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE, S_ALLOC, S_AWAIT, S_ACHK, S_LWAIT, S_POP, S_NEW, S_NDIV, S_SWEEP,
        S_NPOP, S_MUL, S_ADDR, S_FOFF, S_FCHK, S_FDIV1, S_FDIV2, S_FCOMMIT, S_OUT
    } state_t;

    state_t                          state_reg;
    logic [ADDR_W-1:0]               base_reg;
    logic [slab_pkg::SIZE_REG_W-1:0] osize_reg;
    logic [slab_pkg::LIMIT_W-1:0]    limit_reg;
    logic [PTW-1:0]                  pages_taken_reg;
    logic [ADDR_W-1:0]               address_reg;
    logic [ADDR_W-1:0]               off_reg;
    logic [PW-1:0]                   pg_reg;
    logic [PW-1:0]                   page_raddr_reg;
    logic [SW-1:0]                   slot_reg;
    logic [SW-1:0]                   sweep_reg;
    logic [FW-1:0]                   slots_reg;
    logic [PRW-1:0]                  prod_reg;
    logic                            div_start_reg;
    logic [DW-1:0]                   div_dividend_reg;

    slab_pkg::status_t               r_status_reg;
    logic [ADDR_W-1:0]               r_addr_reg;
    logic [slab_pkg::PAGE_OUT_W-1:0] r_page_reg;
    logic [slab_pkg::SLOT_OUT_W-1:0] r_slot_reg;
    logic                            r_took_reg;

    logic                            res_valid_reg;
    slab_pkg::status_t               res_status_reg;
    logic [ADDR_W-1:0]               res_addr_reg;
    logic [slab_pkg::PAGE_OUT_W-1:0] res_page_reg;
    logic [slab_pkg::SLOT_OUT_W-1:0] res_slot_reg;
    logic                            res_took_reg;

    logic [PEW-1:0] page_mem [MAX_PAGES];
    logic [PEW-1:0] page_rdata_reg;
    logic [HW-1:0]  link_mem [LDEPTH];
    logic [HW-1:0]  link_rdata_reg;

    logic                            page_we;
    logic [PEW-1:0]                  page_wdata;
    logic                            link_we;
    logic [HW-1:0]                   link_wdata;
    logic [SW-1:0]                   link_slot;
    logic [LAW-1:0]                  link_addr;
    logic [slab_pkg::SIZE_REG_W-1:0] size_min;
    logic [SZW-1:0]                  eff_size;
    logic [CW-1:0]                   eff_limit;
    logic [FW-1:0]                   slots_calc;
    logic [FW-1:0]                   pg_free;
    logic [HW-1:0]                   pg_head;
    slab_pkg::div_req_t              div_req;
    slab_pkg::div_rsp_t              div_rsp;

    slab_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        size_min = (osize_reg < slab_pkg::SIZE_REG_W'(8)) ? slab_pkg::SIZE_REG_W'(8) : osize_reg;
        eff_size = (SZW'(size_min) + SZW'(7)) & ~SZW'(7);
        eff_limit = (CW'(limit_reg) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(limit_reg);
        if (div_rsp.quotient == '0)
            slots_calc = FW'(1);
        else if (div_rsp.quotient > DW'(MAX_SLOTS))
            slots_calc = FW'(MAX_SLOTS);
        else
            slots_calc = FW'(div_rsp.quotient);
        pg_free   = page_rdata_reg[PEW-1:HW];
        pg_head   = page_rdata_reg[HW-1:0];
        link_slot = (state_reg == S_SWEEP) ? sweep_reg : slot_reg;
        link_addr = LAW'(pg_reg) * LAW'(MAX_SLOTS) + LAW'(link_slot);
        div_req   = '{start: div_start_reg, dividend: div_dividend_reg, divisor: eff_size};
    end

    // memory write controls
    always_comb
    begin
        page_we    = 1'b0;
        page_wdata = '0;
        link_we    = 1'b0;
        link_wdata = '0;
        case (state_reg)
            S_SWEEP:
            begin
                link_we    = 1'b1;
                link_wdata = (sweep_reg == '0) ? LIST_EMPTY : HW'(sweep_reg - SW'(1));
            end
            S_NPOP:
            begin
                page_we    = 1'b1;
                page_wdata = {slots_reg - FW'(1),
                              (slots_reg == FW'(1)) ? LIST_EMPTY : HW'(slots_reg - FW'(2))};
            end
            S_POP:
            begin
                page_we    = 1'b1;
                page_wdata = {pg_free - FW'(1), link_rdata_reg};
            end
            S_FCOMMIT:
            begin
                if (pg_free < slots_reg)
                begin
                    page_we    = 1'b1;
                    page_wdata = {pg_free + FW'(1), HW'(slot_reg)};
                    link_we    = 1'b1;
                    link_wdata = pg_head;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
            page_mem[pg_reg] <= page_wdata;
        page_rdata_reg <= page_mem[page_raddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_addr] <= link_wdata;
        link_rdata_reg <= link_mem[link_addr];
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign res.valid          = res_valid_reg;
    assign res.status         = res_status_reg;
    assign res.object_address = res_addr_reg;
    assign res.page_index     = res_page_reg;
    assign res.slot_index     = res_slot_reg;
    assign res.took_new_page  = res_took_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            base_reg         <= slab_pkg::RST_POOL_BASE;
            osize_reg        <= slab_pkg::RST_OBJECT_SIZE;
            limit_reg        <= slab_pkg::RST_PAGE_LIMIT;
            pages_taken_reg  <= '0;
            address_reg      <= '0;
            off_reg          <= '0;
            pg_reg           <= '0;
            page_raddr_reg   <= '0;
            slot_reg         <= '0;
            sweep_reg        <= '0;
            slots_reg        <= '0;
            prod_reg         <= '0;
            div_start_reg    <= 1'b0;
            div_dividend_reg <= '0;
            r_status_reg     <= slab_pkg::ST_DONE;
            r_addr_reg       <= '0;
            r_page_reg       <= '0;
            r_slot_reg       <= '0;
            r_took_reg       <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_status_reg   <= slab_pkg::ST_DONE;
            res_addr_reg     <= '0;
            res_page_reg     <= '0;
            res_slot_reg     <= '0;
            res_took_reg     <= 1'b0;
        end
        else
        begin
            // the output state reloads the register itself
            if (res_valid_reg && res.ready && state_reg != S_OUT)
                res_valid_reg <= 1'b0;

            if (cfg.valid)
            begin
                case (cfg.index)
                    slab_pkg::CFG_POOL_BASE:   base_reg  <= cfg.data;
                    slab_pkg::CFG_OBJECT_SIZE: osize_reg <= cfg.data[slab_pkg::SIZE_REG_W-1:0];
                    slab_pkg::CFG_PAGE_LIMIT:  limit_reg <= cfg.data[slab_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        address_reg  <= cmd.address;
                        r_status_reg <= slab_pkg::ST_DONE;
                        r_addr_reg   <= '0;
                        r_page_reg   <= '0;
                        r_slot_reg   <= '0;
                        r_took_reg   <= 1'b0;
                        case (cmd.command)
                            slab_pkg::CMD_ALLOC:   state_reg <= S_ALLOC;
                            slab_pkg::CMD_FREE:    state_reg <= S_FOFF;
                            slab_pkg::CMD_RELEASE:
                            begin
                                pages_taken_reg <= '0;
                                state_reg       <= S_OUT;
                            end
                            default:               state_reg <= S_OUT;
                        endcase
                    end
                end
                S_ALLOC:
                begin
                    if (pages_taken_reg == '0)
                        state_reg <= S_NEW;
                    else
                    begin
                        pg_reg         <= PW'(pages_taken_reg - PTW'(1));
                        page_raddr_reg <= PW'(pages_taken_reg - PTW'(1));
                        state_reg      <= S_AWAIT;
                    end
                end
                S_AWAIT: state_reg <= S_ACHK;
                S_ACHK:
                begin
                    // newest page first
                    if (pg_free != '0 && pg_head < HW'(MAX_SLOTS))
                    begin
                        slot_reg  <= pg_head[SW-1:0];
                        state_reg <= S_LWAIT;
                    end
                    else if (pg_reg == '0)
                        state_reg <= S_NEW;
                    else
                    begin
                        pg_reg         <= pg_reg - PW'(1);
                        page_raddr_reg <= pg_reg - PW'(1);
                        state_reg      <= S_AWAIT;
                    end
                end
                S_LWAIT: state_reg <= S_POP;
                S_POP:   state_reg <= S_MUL;
                S_NEW:
                begin
                    if (CW'(pages_taken_reg) >= eff_limit)
                    begin
                        r_status_reg <= slab_pkg::ST_OOM;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        pg_reg           <= PW'(pages_taken_reg);
                        div_dividend_reg <= DW'(AVAIL);
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_NDIV;
                    end
                end
                S_NDIV:
                begin
                    div_start_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        slots_reg <= slots_calc;
                        sweep_reg <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    // chain each fresh slot to the one below it
                    if (FW'(sweep_reg) == slots_reg - FW'(1))
                        state_reg <= S_NPOP;
                    else
                        sweep_reg <= sweep_reg + SW'(1);
                end
                S_NPOP:
                begin
                    pages_taken_reg <= pages_taken_reg + PTW'(1);
                    slot_reg        <= SW'(slots_reg - FW'(1));
                    r_took_reg      <= 1'b1;
                    state_reg       <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= PRW'(slot_reg) * PRW'(eff_size);
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    r_addr_reg <= base_reg + (ADDR_W'(pg_reg) << PSH)
                                  + ADDR_W'(PAGE_HEADER_BYTES) + ADDR_W'(prod_reg);
                    r_page_reg <= slab_pkg::PAGE_OUT_W'(pg_reg);
                    r_slot_reg <= slab_pkg::SLOT_OUT_W'(slot_reg);
                    state_reg  <= S_OUT;
                end
                S_FOFF:
                begin
                    off_reg   <= address_reg - base_reg;
                    state_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    if (off_reg[ADDR_W-1:PSH] >= PGN_W'(pages_taken_reg))
                    begin
                        r_status_reg <= slab_pkg::ST_NO_PAGE;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        pg_reg         <= off_reg[PSH +: PW];
                        page_raddr_reg <= off_reg[PSH +: PW];
                        r_page_reg     <= slab_pkg::PAGE_OUT_W'(off_reg[PSH +: PW]);
                        if (off_reg[PSH-1:0] < DW'(PAGE_HEADER_BYTES))
                        begin
                            r_status_reg <= slab_pkg::ST_BAD_FREE;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            div_dividend_reg <= DW'(AVAIL);
                            div_start_reg    <= 1'b1;
                            state_reg        <= S_FDIV1;
                        end
                    end
                end
                S_FDIV1:
                begin
                    if (div_rsp.done)
                    begin
                        slots_reg        <= slots_calc;
                        div_dividend_reg <= off_reg[PSH-1:0] - DW'(PAGE_HEADER_BYTES);
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_FDIV2;
                    end
                    else
                        div_start_reg <= 1'b0;
                end
                S_FDIV2:
                begin
                    div_start_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        if (div_rsp.remainder != '0 || div_rsp.quotient >= DW'(slots_reg))
                        begin
                            r_status_reg <= slab_pkg::ST_BAD_FREE;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            slot_reg  <= div_rsp.quotient[SW-1:0];
                            state_reg <= S_FCOMMIT;
                        end
                    end
                end
                S_FCOMMIT:
                begin
                    r_slot_reg <= slab_pkg::SLOT_OUT_W'(slot_reg);
                    if (pg_free >= slots_reg)
                        r_status_reg <= slab_pkg::ST_BAD_FREE;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= r_status_reg;
                        res_addr_reg   <= r_addr_reg;
                        res_page_reg   <= r_page_reg;
                        res_slot_reg   <= r_slot_reg;
                        res_took_reg   <= r_took_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_taken_reg <= PTW'(MAX_PAGES))
        else $error("pages taken beyond the pool");

    a_new_page_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NPOP) |=> (pages_taken_reg == $past(pages_taken_reg) + PTW'(1)))
        else $error("opening a page did not advance the page count");

    a_took_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_took_reg) |-> (res_status_reg == slab_pkg::ST_DONE))
        else $error("new page reported on a failed transaction");

    a_free_within_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCOMMIT) |-> (FW'(slot_reg) < slots_reg))
        else $error("free slot beyond the page slot count");

endmodule

`default_nettype wire

// ===== hw/rtl/slab_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module slab_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slab_pkg::div_req_t req,
    output slab_pkg::div_rsp_t      rsp
);

    localparam int DW    = slab_pkg::DIVIDEND_W;
    localparam int SW    = slab_pkg::SIZE_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW-1:0]    quo_reg;
    logic [SW-1:0]    rem_reg;
    logic [SW-1:0]    divisor_reg;
    logic [SW-1:0]    trial;
    logic             fits;

    // remainder stays below the divisor, so its top bit is free for the shift
    always_comb
    begin
        trial = {rem_reg[SW-2:0], quo_reg[DW-1]};
        fits  = (trial >= divisor_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (count_reg == CNT_W'(1));
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                if (count_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? (trial - divisor_reg) : trial;
        end
    end

    assign rsp = '{done: done_reg, quotient: quo_reg, remainder: rem_reg};

endmodule

`default_nettype wire
